// ----- sv/dsam_pkg.sv -----
// ----------------------------------------------------------------------------
// dsam_pkg: shared types and constants for the dual-stream audio mixer
// Field widths, mix mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
package dsam_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CODE_W    = 12;
  localparam int FACTOR_W  = 12;
  localparam int CRUSH_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 12'd2048;

  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_FIRST  = 3'd1,
    MODE_BLEND  = 3'd2,
    MODE_GLITCH = 3'd3,
    MODE_XOR    = 3'd4,
    MODE_AND    = 3'd5,
    MODE_RING   = 3'd6
  } mix_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MUTE          = 3'd0,
    CFG_SINGLE_STREAM = 3'd1,
    CFG_MIX_MODE      = 3'd2,
    CFG_MIX_FACTOR    = 3'd3,
    CFG_CRUSH_BITS    = 3'd4
  } cfg_reg_t;

endpackage

// ----- sv/dual_stream_audio_mixer.sv -----
// ----------------------------------------------------------------------------
// dual_stream_audio_mixer: two-stream sample mixer with 12-bit DAC output
// Mixes two signed samples per beat, crushes low bits, converts to offset
// binary for a 12-bit converter.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// in        in_valid/in_ready    sample_a, sample_b, dither_bit
// out       out_valid/out_ready  dac_code
// cfg       cfg_we (no wait)     cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; a beat passes the
// input register, then mixing logic into the output register that raises out_valid.
// The critical path is one 16x14 multiply plus a 16-bit add, the crush mask
// and the offset decrement.
// A stalled output holds its beat while the input register still takes one
// more beat. Muted beats are accepted and dropped. rst clears all valid flags,
// the configuration registers and the glitch stream select.
// ----------------------------------------------------------------------------
module dual_stream_audio_mixer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dsam_pkg::SAMPLE_W-1:0]   sample_a,
  input  logic [dsam_pkg::SAMPLE_W-1:0]   sample_b,
  input  logic                            dither_bit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dsam_pkg::CODE_W-1:0]     dac_code,
  input  logic                            cfg_we,
  input  logic [dsam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsam_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import dsam_pkg::*;

  // configuration
  logic                mute;
  logic                single_stream;
  mix_mode_t           mix_mode;
  logic [FACTOR_W-1:0] mix_factor;
  logic [CRUSH_W-1:0]  crush_bits;

  // state
  logic stream_select;

  // input register
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_a;
  logic signed [SAMPLE_W-1:0] s1_b;
  logic                       s1_d;

  logic in_take;
  logic out_load;

  // mixing datapath
  logic [FACTOR_W:0]            wgt_a;
  logic signed [29:0]           prod_a;
  logic signed [28:0]           prod_b;
  logic signed [31:0]           prod_r;
  logic [SAMPLE_W-1:0]          blend_v;
  logic                         sel_next;
  logic [SAMPLE_W-1:0]          mix_v;
  logic [SAMPLE_W-1:0]          crush_mask;
  logic [SAMPLE_W-1:0]          crushed;
  logic [SAMPLE_W-1:0]          biased;
  logic [CODE_W-1:0]            dac_code_next;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mute          <= 1'b0;
      single_stream <= 1'b0;
      mix_mode      <= MODE_NONE;
      mix_factor    <= FACTOR_RESET;
      crush_bits    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MUTE:          mute          <= cfg_data[0];
        CFG_SINGLE_STREAM: single_stream <= cfg_data[0];
        CFG_MIX_MODE:      mix_mode      <= mix_mode_t'(cfg_data[2:0]);
        CFG_MIX_FACTOR:    mix_factor    <= cfg_data[FACTOR_W-1:0];
        CFG_CRUSH_BITS:    crush_bits    <= cfg_data[CRUSH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wgt_a   = (FACTOR_W+1)'(1 << FACTOR_W) - {1'b0, mix_factor};
    prod_a  = s1_a * $signed({1'b0, wgt_a});
    prod_b  = s1_b * $signed({1'b0, mix_factor});
    prod_r  = s1_a * s1_b;
    // floor shift by 12, only the low 16 bits of the sum survive
    blend_v = (prod_a[27:12] + prod_b[27:12]) ^ {{(SAMPLE_W-1){1'b0}}, s1_d};
    sel_next = stream_select ^ (s1_a == s1_b);

    if (single_stream) begin
      mix_v = s1_a;
    end else begin
      case (mix_mode)
        MODE_FIRST:  mix_v = s1_a;
        MODE_BLEND:  mix_v = blend_v;
        MODE_GLITCH: mix_v = sel_next ? s1_b : s1_a;
        MODE_XOR:    mix_v = s1_a ^ s1_b;
        MODE_AND:    mix_v = s1_a & s1_b;
        MODE_RING:   mix_v = prod_r[31:16];
        default:     mix_v = '0;
      endcase
    end

    crush_mask = {SAMPLE_W{1'b1}} << crush_bits;
    crushed    = mix_v & crush_mask;
    // v + 0x8000 as unsigned; code is (that - 1) >> 4, clamped at zero
    biased     = crushed ^ {1'b1, {(SAMPLE_W-1){1'b0}}};
    if (biased == '0) begin
      dac_code_next = '0;
    end else begin
      dac_code_next = CODE_W'((biased - SAMPLE_W'(1)) >> (SAMPLE_W - CODE_W));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      stream_select <= 1'b0;
    end else begin
      // drop muted beats at the door
      if (in_take) begin
        s1_valid <= !mute;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (out_load && !single_stream && mix_mode == MODE_GLITCH) begin
        stream_select <= sel_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_a <= sample_a;
      s1_b <= sample_b;
      s1_d <= dither_bit;
    end
    if (out_load) begin
      dac_code <= dac_code_next;
    end
  end

endmodule

// ----- sv/dsam_checker.sv -----
// ----------------------------------------------------------------------------
// dsam_checker: port-level checks for the dual-stream audio mixer
// Watches handshakes and the mute register as written through the cfg port.
// ----------------------------------------------------------------------------
module dsam_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dsam_pkg::CODE_W-1:0]     dac_code,
  input logic                            cfg_we,
  input logic [dsam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [dsam_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import dsam_pkg::*;

  logic mute_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mute_seen <= 1'b0;
    end else if (cfg_we && cfg_index == CFG_MUTE) begin
      mute_seen <= cfg_data[0];
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dac_code))
    else $error("stalled output beat changed");

  a_muted_silent: assert property (@(posedge clk) disable iff (rst)
    mute_seen && !out_valid |=> !out_valid)
    else $error("output beat while muted");

  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output beat without matching input beat");

endmodule

bind dual_stream_audio_mixer dsam_checker u_dsam_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .dac_code  (dac_code),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dual-stream audio mixer
// Walks a table of directed beats across every mix mode, the clamp and crush
// corners, mute and single-stream. Then runs random configuration phases with
// random beats and random gaps and stalls on both channels. Every output beat
// is checked against a local model of the mixer, or for typed rows against the table code.
// ----------------------------------------------------------------------------
module tb;
  import dsam_pkg::*;

  localparam int CLK_HALF_NS   = 4;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_BEATS  = 2000;
  localparam int CALM_BEATS    = 200;
  localparam int PIPE_SETTLE   = 6;
  localparam int TIMEOUT_NS    = 4_000_000;
  localparam int BLEND_ONE     = 4096;
  localparam int BLEND_SHIFT   = 12;
  localparam int RING_SHIFT    = 16;
  localparam int DAC_OFFSET    = 32'sh7FFF;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [11:0] CODE_MID  = 12'd2047;
  localparam logic [11:0] CODE_TOP  = 12'd4095;
  localparam logic [11:0] CODE_ZERO = 12'd0;

  typedef struct packed {
    logic        mute;
    logic        single;
    logic [2:0]  mode;
    logic [11:0] factor;
    logic [3:0]  crush;
    logic [15:0] a;
    logic [15:0] b;
    logic        d;
    logic        typed;
    logic [11:0] code;
  } beat_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  sample_a = '0;
  logic [SAMPLE_W-1:0]  sample_b = '0;
  logic                 dither_bit = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [CODE_W-1:0]    dac_code;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // shadow of the mixer configuration and glitch state
  logic        cfg_mute   = 1'b0;
  logic        cfg_single = 1'b0;
  logic [2:0]  cfg_mode   = MODE_NONE;
  logic [11:0] cfg_factor = FACTOR_RESET;
  logic [3:0]  cfg_crush  = '0;
  logic        glitch_sel = 1'b0;

  logic [11:0] dac_expect_q[$];
  int          mismatch_cnt = 0;
  bit          calm = 1'b0;

  dual_stream_audio_mixer uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_a   (sample_a),
    .sample_b   (sample_b),
    .dither_bit (dither_bit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dac_code   (dac_code),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mix one sample pair into a DAC code; returns 0 when muted.
  function automatic bit mix_sample(input logic signed [15:0] a, input logic signed [15:0] b,
                                    input logic d, output logic [11:0] code);
    int          sa;
    int          sb;
    int          acc;
    int          off;
    logic [15:0] v;
    code = '0;
    if (cfg_mute) return 1'b0;
    sa = a;
    sb = b;
    if (cfg_single) begin
      v = a;
    end else begin
      case (cfg_mode)
        MODE_FIRST: v = a;
        MODE_BLEND: begin
          acc = ((sa * (BLEND_ONE - int'(cfg_factor))) >>> BLEND_SHIFT)
              + ((sb * int'(cfg_factor)) >>> BLEND_SHIFT);
          v = acc[15:0] ^ {15'b0, d};
        end
        MODE_GLITCH: begin
          if (a == b) glitch_sel = ~glitch_sel;
          v = glitch_sel ? b : a;
        end
        MODE_XOR: v = a ^ b;
        MODE_AND: v = a & b;
        MODE_RING: begin
          acc = (sa * sb) >>> RING_SHIFT;
          v = acc[15:0];
        end
        default: v = '0;
      endcase
    end
    v = v & (16'hFFFF << cfg_crush);
    off = int'($signed(v)) + DAC_OFFSET;
    // only the most negative sample drops below zero
    if (off < 0) off = 0;
    code = off[15:4];
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [11:0] want,
                               input logic [11:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s dac_code expected %0d got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : out_check
    logic [11:0] want;
    if (!rst && out_valid && out_ready) begin
      if (dac_expect_q.size() == 0) begin
        flag_mismatch("unexpected beat:", 'x, dac_code);
      end else begin
        want = dac_expect_q.pop_front();
        if (dac_code !== want) flag_mismatch("mismatch:", want, dac_code);
      end
    end
  end

  // Output back-pressure: random stall and run bursts, none once calm.
  initial begin : ready_gen
    int n;
    forever begin
      if (calm || rst) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Called at a clock edge; returns at the edge where the beat was taken.
  task automatic send_beat(input logic [15:0] a, input logic [15:0] b, input logic d,
                           input logic typed, input logic [11:0] typed_code);
    logic [11:0] code;
    in_valid   <= 1'b1;
    sample_a   <= a;
    sample_b   <= b;
    dither_bit <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (mix_sample(a, b, d, code))
      dac_expect_q.insert(dac_expect_q.size(), typed ? typed_code : code);
  endtask

  task automatic idle_gap();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 13);
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold input low until every pending beat is out, plus muted beats in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (dac_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic m, input logic s, input logic [2:0] mode,
                              input logic [11:0] f, input logic [3:0] c);
    write_reg(CFG_MUTE, {11'b0, m});
    write_reg(CFG_SINGLE_STREAM, {11'b0, s});
    write_reg(CFG_MIX_MODE, {9'b0, mode});
    write_reg(CFG_MIX_FACTOR, f);
    write_reg(CFG_CRUSH_BITS, {8'b0, c});
    cfg_we     <= 1'b0;
    cfg_mute   = m;
    cfg_single = s;
    cfg_mode   = mode;
    cfg_factor = f;
    cfg_crush  = c;
  endtask

  beat_row_t directed_rows [25] = '{
    // reset configuration: mode none gives the mid code
    '{1'b0, 1'b0, MODE_NONE,   12'd2048, 4'd0,  16'h7FFF, 16'h8000, 1'b1, 1'b1, CODE_MID},
    '{1'b0, 1'b0, MODE_UNUSED, 12'd2048, 4'd0,  16'h1234, 16'h4321, 1'b0, 1'b1, CODE_MID},
    '{1'b0, 1'b0, MODE_FIRST,  12'd2048, 4'd0,  16'h7FFF, 16'h0000, 1'b0, 1'b1, CODE_TOP},
    '{1'b0, 1'b0, MODE_FIRST,  12'd2048, 4'd0,  16'h8000, 16'h0000, 1'b0, 1'b1, CODE_ZERO},
    '{1'b0, 1'b0, MODE_FIRST,  12'd2048, 4'd0,  16'h0000, 16'hFFFF, 1'b1, 1'b1, CODE_MID},
    '{1'b0, 1'b0, MODE_FIRST,  12'd2048, 4'd0,  16'hFFFF, 16'h0000, 1'b0, 1'b1, CODE_MID},
    '{1'b0, 1'b0, MODE_FIRST,  12'd2048, 4'd15, 16'h7FFF, 16'h0000, 1'b0, 1'b1, CODE_MID},
    '{1'b0, 1'b0, MODE_FIRST,  12'd2048, 4'd15, 16'hFFFF, 16'h0000, 1'b0, 1'b1, CODE_ZERO},
    '{1'b0, 1'b0, MODE_FIRST,  12'd2048, 4'd4,  16'hFFFF, 16'h0000, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_BLEND,  12'd0,    4'd0,  16'h7FFF, 16'h8000, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_BLEND,  12'd4095, 4'd0,  16'h8000, 16'h7FFF, 1'b1, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_BLEND,  12'd2048, 4'd0,  16'h8000, 16'h8000, 1'b1, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_XOR,    12'd2048, 4'd0,  16'h7FFF, 16'h8000, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_AND,    12'd2048, 4'd0,  16'hFFFF, 16'h8000, 1'b1, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_RING,   12'd2048, 4'd0,  16'h8000, 16'h8000, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_RING,   12'd2048, 4'd0,  16'h7FFF, 16'h8000, 1'b0, 1'b0, CODE_ZERO},
    // glitch: equal samples flip the stream choice
    '{1'b0, 1'b0, MODE_GLITCH, 12'd2048, 4'd0,  16'h1234, 16'h5678, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_GLITCH, 12'd2048, 4'd0,  16'h5555, 16'h5555, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_GLITCH, 12'd2048, 4'd0,  16'h1111, 16'h2222, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b1, MODE_RING,   12'd2048, 4'd0,  16'h7FFF, 16'h0000, 1'b0, 1'b1, CODE_TOP},
    // single stream and mute must leave the glitch choice alone
    '{1'b0, 1'b1, MODE_GLITCH, 12'd2048, 4'd0,  16'h4444, 16'h4444, 1'b0, 1'b0, CODE_ZERO},
    '{1'b1, 1'b0, MODE_FIRST,  12'd2048, 4'd0,  16'h7FFF, 16'h0000, 1'b0, 1'b0, CODE_ZERO},
    '{1'b1, 1'b0, MODE_GLITCH, 12'd2048, 4'd0,  16'h3333, 16'h3333, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_GLITCH, 12'd2048, 4'd0,  16'h0100, 16'h0200, 1'b0, 1'b0, CODE_ZERO},
    '{1'b0, 1'b0, MODE_GLITCH, 12'd2048, 4'd0,  16'h8000, 16'h8000, 1'b1, 1'b0, CODE_ZERO}
  };

  initial begin : stimulus
    beat_row_t   r;
    int          random_beats;
    int          phase_len;
    logic        m;
    logic        s;
    logic [2:0]  mode;
    logic [11:0] f;
    logic [3:0]  c;
    logic [15:0] a;
    logic [15:0] b;
    random_beats = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if ({r.mute, r.single, r.mode, r.factor, r.crush} !=
          {cfg_mute, cfg_single, cfg_mode, cfg_factor, cfg_crush}) begin
        wait_idle();
        apply_config(r.mute, r.single, r.mode, r.factor, r.crush);
      end
      send_beat(r.a, r.b, r.d, r.typed, r.code);
    end

    while (random_beats < RANDOM_BEATS) begin
      m    = ($urandom_range(0, 9) == 0);
      s    = ($urandom_range(0, 5) == 0);
      mode = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: f = '0;
        1: f = 12'hFFF;
        default: f = 12'($urandom);
      endcase
      c = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
      wait_idle();
      apply_config(m, s, mode, f, c);
      phase_len = m ? $urandom_range(5, 15) : $urandom_range(20, 80);
      repeat (phase_len) begin
        a = pick_sample();
        b = (cfg_mode == MODE_GLITCH && $urandom_range(0, 2) == 0) ? a : pick_sample();
        send_beat(a, b, 1'($urandom_range(0, 1)), 1'b0, CODE_ZERO);
        if (!m) random_beats++;
        // last stretch runs flat out on both channels
        if (random_beats >= RANDOM_BEATS - CALM_BEATS) calm = 1'b1;
        idle_gap();
      end
    end

    wait_idle();
    repeat (PIPE_SETTLE) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dsam_pkg.sv
sv/dual_stream_audio_mixer.sv
sv/dsam_checker.sv
dv/tb.sv
